FILE: hw/rtl/bdm_pkg.sv
// bdm_pkg: shared types and constants of the bayer demosaic colour pipeline
// item structs, configuration structs, register indexes and fixed constants
// depends on nothing
`timescale 1ns / 1ps

package bdm_pkg;

  // kind of request carried through the pipeline
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_TABLE = 1'b1
  } kind_t;

  // configuration register indexes
  typedef enum logic [3:0] {
    REG_BLACK_OFFSET  = 4'd0,
    REG_GAIN_RED      = 4'd1,
    REG_GAIN_GREEN    = 4'd2,
    REG_GAIN_BLUE     = 4'd3,
    REG_GAMMA_ENABLE  = 4'd4,
    REG_DEMOSAIC_MODE = 4'd5,
    REG_FRAME_WIDTH   = 4'd6,
    REG_FRAME_HEIGHT  = 4'd7
  } reg_index_t;

  // bayer phase of a centre sample: {row parity, column parity}
  typedef enum logic [1:0] {
    PH_GREEN_B = 2'd0,
    PH_BLUE    = 2'd1,
    PH_RED     = 2'd2,
    PH_GREEN_R = 2'd3
  } phase_t;

  localparam int CFG_IW      = 4;
  localparam int CFG_DW      = 16;
  localparam int GAMMA_DEPTH = 1024;
  localparam int GAMMA_AW    = 10;
  localparam int MIN_SIZE    = 4;
  localparam int MID_DEPTH   = 4;
  localparam int OUT_DEPTH   = 4;
  localparam int MQ_CW       = $clog2(MID_DEPTH + 1);
  localparam int OQ_CW       = $clog2(OUT_DEPTH + 1);

  localparam logic [9:0] PIX_MAX  = 10'd1023;
  localparam logic [7:0] CHAN_MAX = 8'd255;

  // reset values of the registers
  localparam logic [9:0]  RST_BLACK_OFFSET = 10'd16;
  localparam logic [15:0] RST_GAIN         = 16'd256;
  localparam logic        RST_GAMMA_ENABLE = 1'b1;
  localparam logic        RST_DEMOSAIC     = 1'b1;
  localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;

  typedef struct packed {
    logic       action;
    logic [9:0] pixel_value;
    logic [9:0] table_index;
    logic [7:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] out_column;
    logic [11:0] out_row;
    logic        run_last;
  } out_item_t;

  // one request between front and back
  typedef struct packed {
    kind_t       kind;
    logic [9:0]  raw_red;
    logic [9:0]  raw_green;
    logic [9:0]  raw_blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last;
    logic [9:0]  table_index;
    logic [7:0]  table_value;
  } work_item_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic        demosaic_mode;
  } front_cfg_t;

  typedef struct packed {
    logic [9:0]  black_offset;
    logic [15:0] gain_red;
    logic [15:0] gain_green;
    logic [15:0] gain_blue;
    logic        gamma_enable;
  } back_cfg_t;

endpackage

FILE: hw/rtl/bdm_ram.sv
// bdm_ram: generic single write port, single read port ram
// registered read with enable, read returns old data on a same address write
`timescale 1ns / 1ps

module bdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // storage array and read register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/bdm_fifo.sv
// bdm_fifo: small register queue with occupancy count
// generic width and depth, no package dependency
`timescale 1ns / 1ps

module bdm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: hw/rtl/bdm_front.sv
// bdm_front: raster counters, line buffers, 3x3 window and demosaic
// classifies each request and emits one work item per cycle while the work queue has room; uses bdm_pkg, bdm_ram
`timescale 1ns / 1ps

module bdm_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bdm_pkg::front_cfg_t   cfg,
  input  logic                  in_push,
  input  bdm_pkg::in_item_t     in_data,
  output logic                  in_full,
  input  logic                  mq_full,
  output logic                  mq_push,
  output bdm_pkg::work_item_t   mq_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int SW = $clog2(MAX_WIDTH + 1);
  localparam int TW = $clog2(MAX_HEIGHT + 1);

  // saturated frame size
  logic [SW-1:0] width_s;
  logic [TW-1:0] height_s;

  always_comb begin
    if (cfg.frame_width < 13'(bdm_pkg::MIN_SIZE)) begin
      width_s = SW'(bdm_pkg::MIN_SIZE);
    end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
      width_s = SW'(MAX_WIDTH);
    end else begin
      width_s = SW'(cfg.frame_width);
    end
    if (cfg.frame_height < 13'(bdm_pkg::MIN_SIZE)) begin
      height_s = TW'(bdm_pkg::MIN_SIZE);
    end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
      height_s = TW'(MAX_HEIGHT);
    end else begin
      height_s = TW'(cfg.frame_height);
    end
  end

  // raster counters
  logic [XW-1:0] col_r, col_nxt, x_cur;
  logic [YW-1:0] row_r, row_nxt, y_cur;
  logic          accept, is_pix, x_wrap;

  // stage a: request waiting for line buffer data
  logic           a_v_r, a_v_nxt;
  bdm_pkg::kind_t a_kind_r;
  logic [9:0]     a_pix_r;
  logic [XW-1:0]  a_x_r;
  logic [YW-1:0]  a_y_r;
  logic [9:0]     a_tidx_r;
  logic [7:0]     a_tval_r;
  logic           a_go;

  // stage b: emitter of up to four work items
  logic           b_v_r, b_v_nxt;
  bdm_pkg::kind_t b_kind_r;
  logic           b_x0_r, b_y0_r;
  logic [YW-1:0]  b_r0_r, b_r1_r;
  logic [XW-1:0]  b_c0_r, b_c1_r;
  logic           b_nr2_r, b_nc2_r;
  logic [1:0]     b_k_r, b_k_nxt;
  logic [9:0]     b_tidx_r;
  logic [7:0]     b_tval_r;
  logic           b_last, b_done;

  logic [9:0] bank0_rd, bank1_rd, row_up, row_mid;
  logic [9:0] win_r [3][3];

  assign is_pix = (bdm_pkg::kind_t'(in_data.action) == bdm_pkg::KIND_PIXEL);
  assign in_full = a_v_r && !a_go;
  assign accept  = in_push && !in_full;

  // position of the incoming pixel, wrapped if the size shrank
  always_comb begin
    x_cur  = (col_r >= width_s) ? '0 : col_r;
    y_cur  = (row_r >= height_s) ? '0 : row_r;
    x_wrap = ((SW'(x_cur) + SW'(1)) >= width_s);
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept && is_pix) begin
      if (x_wrap) begin
        col_nxt = '0;
        row_nxt = ((TW'(y_cur) + TW'(1)) >= height_s) ? '0 : y_cur + 1'b1;
      end else begin
        col_nxt = x_cur + 1'b1;
        row_nxt = y_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // two line buffer banks, selected by row parity
  bdm_ram #(.WIDTH(10), .DEPTH(MAX_WIDTH)) u_bank0 (
    .clk   (clk),
    .we    (accept && is_pix && !y_cur[0]),
    .waddr (x_cur),
    .wdata (in_data.pixel_value),
    .re    (accept && is_pix),
    .raddr (x_cur),
    .rdata (bank0_rd)
  );

  bdm_ram #(.WIDTH(10), .DEPTH(MAX_WIDTH)) u_bank1 (
    .clk   (clk),
    .we    (accept && is_pix && y_cur[0]),
    .waddr (x_cur),
    .wdata (in_data.pixel_value),
    .re    (accept && is_pix),
    .raddr (x_cur),
    .rdata (bank1_rd)
  );

  assign row_up  = a_y_r[0] ? bank1_rd : bank0_rd;
  assign row_mid = a_y_r[0] ? bank0_rd : bank1_rd;

  // stage a register
  assign a_v_nxt = accept ? 1'b1 : (a_go ? 1'b0 : a_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind_r <= bdm_pkg::kind_t'(in_data.action);
      a_pix_r  <= in_data.pixel_value;
      a_x_r    <= x_cur;
      a_y_r    <= y_cur;
      a_tidx_r <= in_data.table_index;
      a_tval_r <= in_data.table_value;
    end
  end

  // emission set of the pixel in stage a
  logic          a_emit, a_ytwo, a_xtwo, a_ylast, a_xlast, a_load;
  logic [YW-1:0] a_r0, a_r1;
  logic [XW-1:0] a_c0, a_c1;

  always_comb begin
    a_emit  = (a_y_r >= YW'(2)) && (a_x_r >= XW'(2));
    a_ytwo  = (a_y_r == YW'(2));
    a_xtwo  = (a_x_r == XW'(2));
    a_ylast = (TW'(a_y_r) == height_s - 1'b1);
    a_xlast = (SW'(a_x_r) == width_s - 1'b1);
    a_r0    = a_ytwo ? '0 : a_y_r - 1'b1;
    a_r1    = a_ytwo ? YW'(1) : YW'(height_s - 1'b1);
    a_c0    = a_xtwo ? '0 : a_x_r - 1'b1;
    a_c1    = a_xtwo ? XW'(1) : XW'(width_s - 1'b1);
    a_load  = (a_kind_r == bdm_pkg::KIND_TABLE) || a_emit;
  end

  assign a_go = a_v_r && (!b_v_r || b_done);

  // window shift as the pixel leaves stage a
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (a_go && a_kind_r == bdm_pkg::KIND_PIXEL) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= row_up;
      win_r[1][2] <= row_mid;
      win_r[2][2] <= a_pix_r;
    end
  end

  // emitter index and output selection
  logic          sel_i, sel_j;
  logic [YW-1:0] orow;
  logic [XW-1:0] ocol;

  always_comb begin
    sel_i  = b_nc2_r ? b_k_r[1] : b_k_r[0];
    sel_j  = b_nc2_r ? b_k_r[0] : 1'b0;
    orow   = sel_i ? b_r1_r : b_r0_r;
    ocol   = sel_j ? b_c1_r : b_c0_r;
    b_last = (b_kind_r == bdm_pkg::KIND_TABLE) ||
             ((sel_i == b_nr2_r) && (sel_j == b_nc2_r));
  end

  assign mq_push = b_v_r && !mq_full;
  assign b_done  = mq_push && b_last;

  always_comb begin
    b_v_nxt = b_v_r;
    b_k_nxt = b_k_r;
    if (a_go) begin
      b_v_nxt = a_load;
      b_k_nxt = '0;
    end else if (b_done) begin
      b_v_nxt = 1'b0;
    end else if (mq_push) begin
      b_k_nxt = b_k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      b_k_r <= '0;
    end else begin
      b_v_r <= b_v_nxt;
      b_k_r <= b_k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_kind_r <= a_kind_r;
      b_x0_r   <= a_x_r[0];
      b_y0_r   <= a_y_r[0];
      b_r0_r   <= a_r0;
      b_r1_r   <= a_r1;
      b_c0_r   <= a_c0;
      b_c1_r   <= a_c1;
      b_nr2_r  <= a_ytwo || a_ylast;
      b_nc2_r  <= a_xtwo || a_xlast;
      b_tidx_r <= a_tidx_r;
      b_tval_r <= a_tval_r;
    end
  end

  // bilinear estimates around the window centre
  logic [9:0] hz, vt, cr, dgl;

  always_comb begin
    logic [10:0] s_h, s_v;
    logic [11:0] s_c, s_d;
    s_h = 11'(win_r[1][0]) + 11'(win_r[1][2]);
    s_v = 11'(win_r[0][1]) + 11'(win_r[2][1]);
    s_c = 12'(s_h) + 12'(s_v);
    s_d = 12'(win_r[0][0]) + 12'(win_r[0][2]) + 12'(win_r[2][0]) + 12'(win_r[2][2]);
    hz  = s_h[10:1];
    vt  = s_v[10:1];
    cr  = s_c[11:2];
    dgl = s_d[11:2];
  end

  // nearest neighbour 2x2 block of the output pixel
  logic       nh0, nc0, dr, dc;
  logic [9:0] q_a, q_rt, q_bl, q_dg;

  always_comb begin
    nh0 = orow[0] ^ (TW'(orow) == height_s - 1'b1);
    nc0 = ocol[0] ^ (SW'(ocol) == width_s - 1'b1);
    dr  = nh0 ^ b_y0_r;
    dc  = nc0 ^ b_x0_r;
    case ({dr, dc})
      2'b00: begin
        q_a = win_r[0][0]; q_rt = win_r[0][1]; q_bl = win_r[1][0]; q_dg = win_r[1][1];
      end
      2'b01: begin
        q_a = win_r[0][1]; q_rt = win_r[0][2]; q_bl = win_r[1][1]; q_dg = win_r[1][2];
      end
      2'b10: begin
        q_a = win_r[1][0]; q_rt = win_r[1][1]; q_bl = win_r[2][0]; q_dg = win_r[2][1];
      end
      default: begin
        q_a = win_r[1][1]; q_rt = win_r[1][2]; q_bl = win_r[2][1]; q_dg = win_r[2][2];
      end
    endcase
  end

  // colour assignment by bayer phase
  logic [9:0] dm_r, dm_g, dm_b;

  always_comb begin
    dm_r = '0;
    dm_g = '0;
    dm_b = '0;
    if (cfg.demosaic_mode) begin
      case (bdm_pkg::phase_t'({~b_y0_r, ~b_x0_r}))
        bdm_pkg::PH_GREEN_B: begin dm_g = win_r[1][1]; dm_b = hz; dm_r = vt; end
        bdm_pkg::PH_BLUE:    begin dm_b = win_r[1][1]; dm_g = cr; dm_r = dgl; end
        bdm_pkg::PH_RED:     begin dm_r = win_r[1][1]; dm_g = cr; dm_b = dgl; end
        default:             begin dm_g = win_r[1][1]; dm_r = hz; dm_b = vt; end
      endcase
    end else begin
      case (bdm_pkg::phase_t'({nh0, nc0}))
        bdm_pkg::PH_GREEN_B: begin dm_g = q_a; dm_b = q_rt; dm_r = q_bl; end
        bdm_pkg::PH_BLUE:    begin dm_b = q_a; dm_g = q_rt; dm_r = q_dg; end
        bdm_pkg::PH_RED:     begin dm_r = q_a; dm_g = q_rt; dm_b = q_dg; end
        default:             begin dm_g = q_a; dm_r = q_rt; dm_b = q_bl; end
      endcase
    end
  end

  // work item towards the back end
  always_comb begin
    mq_data.kind        = b_kind_r;
    mq_data.raw_red     = dm_r;
    mq_data.raw_green   = dm_g;
    mq_data.raw_blue    = dm_b;
    mq_data.column      = 12'(ocol);
    mq_data.row         = 12'(orow);
    mq_data.last        = b_last;
    mq_data.table_index = b_tidx_r;
    mq_data.table_value = b_tval_r;
  end

endmodule

FILE: hw/rtl/bdm_back.sv
// bdm_back: black offset, gain, gamma lookup and saturation
// two stage pipeline with output credit check; uses bdm_pkg, bdm_ram
`timescale 1ns / 1ps

module bdm_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bdm_pkg::back_cfg_t                cfg,
  input  logic                              mq_empty,
  input  bdm_pkg::work_item_t               mq_data,
  output logic                              mq_pop,
  input  logic [bdm_pkg::OQ_CW-1:0]         oq_count,
  output logic                              oq_push,
  output bdm_pkg::out_item_t                oq_data
);

  localparam int UW = bdm_pkg::OQ_CW + 1;

  function automatic logic [25:0] scale(input logic [9:0] v, input logic [9:0] bo,
                                        input logic [15:0] g);
    logic [9:0] d;
    d = (v > bo) ? v - bo : '0;
    return g * d;
  endfunction

  logic                c_v_r, d_v_r;
  bdm_pkg::work_item_t c_item_r, d_item_r;
  logic [25:0]         c_p_r [3];
  logic [7:0]          d_lin_r [3];
  logic [9:0]          g_addr [3];
  logic [7:0]          g_lin [3];
  logic [7:0]          g_rd [3];
  logic [UW-1:0]       used;

  // issue only when the output queue has room for everything in flight
  assign used   = UW'(oq_count) + UW'(c_v_r) + UW'(d_v_r);
  assign mq_pop = !mq_empty && (used < UW'(bdm_pkg::OUT_DEPTH));

  // stage c: offset removal and gain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      c_v_r <= mq_pop;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mq_pop) begin
      c_item_r <= mq_data;
      c_p_r[0] <= scale(mq_data.raw_red,   cfg.black_offset, cfg.gain_red);
      c_p_r[1] <= scale(mq_data.raw_green, cfg.black_offset, cfg.gain_green);
      c_p_r[2] <= scale(mq_data.raw_blue,  cfg.black_offset, cfg.gain_blue);
    end
  end

  // stage d: clamp into table range, linear path shifted and saturated
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      g_addr[ch] = (|c_p_r[ch][25:18]) ? bdm_pkg::PIX_MAX : c_p_r[ch][17:8];
      g_lin[ch]  = (|c_p_r[ch][25:18]) ? bdm_pkg::CHAN_MAX : c_p_r[ch][17:10];
    end
  end

  // one gamma table copy per channel, all written together
  for (genvar ch = 0; ch < 3; ch++) begin : g_gamma
    bdm_ram #(.WIDTH(8), .DEPTH(bdm_pkg::GAMMA_DEPTH)) u_gamma (
      .clk   (clk),
      .we    (c_v_r && c_item_r.kind == bdm_pkg::KIND_TABLE),
      .waddr (c_item_r.table_index),
      .wdata (c_item_r.table_value),
      .re    (c_v_r && c_item_r.kind == bdm_pkg::KIND_PIXEL),
      .raddr (g_addr[ch]),
      .rdata (g_rd[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (c_v_r) begin
      d_item_r <= c_item_r;
      for (int ch = 0; ch < 3; ch++) begin
        d_lin_r[ch] <= g_lin[ch];
      end
    end
  end

  // result selection into the output queue
  assign oq_push = d_v_r && d_item_r.kind == bdm_pkg::KIND_PIXEL;

  always_comb begin
    oq_data.red        = cfg.gamma_enable ? g_rd[0] : d_lin_r[0];
    oq_data.green      = cfg.gamma_enable ? g_rd[1] : d_lin_r[1];
    oq_data.blue       = cfg.gamma_enable ? g_rd[2] : d_lin_r[2];
    oq_data.out_column = d_item_r.column;
    oq_data.out_row    = d_item_r.row;
    oq_data.run_last   = d_item_r.last;
  end

endmodule

FILE: hw/rtl/bayer_demosaic_color_pipeline_unit.sv
// bayer_demosaic_color_pipeline_unit: top level of the demosaic colour pipeline
// holds configuration registers, joins front, work queue, back and output queue
// depends on bdm_pkg, bdm_front, bdm_back, bdm_fifo, bdm_ram
//
//   channel   direction  handshake          payload
//   input     in         push / full        in_data   (bdm_pkg::in_item_t)
//   result    out        pop / empty        out_data  (bdm_pkg::out_item_t)
//   config    in         cfg_we             cfg_index, cfg_wdata
//
// one request per cycle while each pixel gives at most one result and the work queue
// has room; a pixel at a frame edge that gives two to four results holds the input
// until the single work item per cycle emitter ahead of the work queue has sent
// them all.
// reset is synchronous; line buffers and gamma table are not cleared.
// either side may stall: the work queue and output queue decouple front, back and sink.
`timescale 1ns / 1ps

module bayer_demosaic_color_pipeline_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  bdm_pkg::in_item_t            in_data,
  output logic                         full,
  input  logic                         pop,
  output bdm_pkg::out_item_t           out_data,
  output logic                         empty,
  input  logic                         cfg_we,
  input  logic [bdm_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [bdm_pkg::CFG_DW-1:0]   cfg_wdata
);

  // configuration registers
  logic [9:0]  black_offset_r;
  logic [15:0] gain_red_r, gain_green_r, gain_blue_r;
  logic        gamma_enable_r, demosaic_mode_r;
  logic [12:0] frame_width_r, frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_offset_r  <= bdm_pkg::RST_BLACK_OFFSET;
      gain_red_r      <= bdm_pkg::RST_GAIN;
      gain_green_r    <= bdm_pkg::RST_GAIN;
      gain_blue_r     <= bdm_pkg::RST_GAIN;
      gamma_enable_r  <= bdm_pkg::RST_GAMMA_ENABLE;
      demosaic_mode_r <= bdm_pkg::RST_DEMOSAIC;
      frame_width_r   <= bdm_pkg::RST_FRAME_WIDTH;
      frame_height_r  <= bdm_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      case (bdm_pkg::reg_index_t'(cfg_index))
        bdm_pkg::REG_BLACK_OFFSET:  black_offset_r  <= cfg_wdata[9:0];
        bdm_pkg::REG_GAIN_RED:      gain_red_r      <= cfg_wdata;
        bdm_pkg::REG_GAIN_GREEN:    gain_green_r    <= cfg_wdata;
        bdm_pkg::REG_GAIN_BLUE:     gain_blue_r     <= cfg_wdata;
        bdm_pkg::REG_GAMMA_ENABLE:  gamma_enable_r  <= cfg_wdata[0];
        bdm_pkg::REG_DEMOSAIC_MODE: demosaic_mode_r <= cfg_wdata[0];
        bdm_pkg::REG_FRAME_WIDTH:   frame_width_r   <= cfg_wdata[12:0];
        bdm_pkg::REG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  bdm_pkg::front_cfg_t front_cfg;
  bdm_pkg::back_cfg_t  back_cfg;

  always_comb begin
    front_cfg.frame_width   = frame_width_r;
    front_cfg.frame_height  = frame_height_r;
    front_cfg.demosaic_mode = demosaic_mode_r;
    back_cfg.black_offset   = black_offset_r;
    back_cfg.gain_red       = gain_red_r;
    back_cfg.gain_green     = gain_green_r;
    back_cfg.gain_blue      = gain_blue_r;
    back_cfg.gamma_enable   = gamma_enable_r;
  end

  // front end
  logic                            mq_push, mq_full, mq_pop, mq_empty;
  logic [bdm_pkg::MQ_CW-1:0]       mq_count;
  bdm_pkg::work_item_t             mq_din, mq_dout;

  bdm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (front_cfg),
    .in_push (push),
    .in_data (in_data),
    .in_full (full),
    .mq_full (mq_full),
    .mq_push (mq_push),
    .mq_data (mq_din)
  );

  // work queue between front and back
  bdm_fifo #(.WIDTH($bits(bdm_pkg::work_item_t)), .DEPTH(bdm_pkg::MID_DEPTH)) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .din   (mq_din),
    .pop   (mq_pop),
    .dout  (mq_dout),
    .full  (mq_full),
    .empty (mq_empty),
    .count (mq_count)
  );

  // back end
  logic                      oq_push, oq_full;
  logic [bdm_pkg::OQ_CW-1:0] oq_count;
  bdm_pkg::out_item_t        oq_din;

  bdm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (back_cfg),
    .mq_empty (mq_empty),
    .mq_data  (mq_dout),
    .mq_pop   (mq_pop),
    .oq_count (oq_count),
    .oq_push  (oq_push),
    .oq_data  (oq_din)
  );

  // output queue towards the sink
  bdm_fifo #(.WIDTH($bits(bdm_pkg::out_item_t)), .DEPTH(bdm_pkg::OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_din),
    .pop   (pop),
    .dout  (out_data),
    .full  (oq_full),
    .empty (empty),
    .count (oq_count)
  );

  // the emitter only pushes into a work queue with room
  a_work_room: assert property (@(posedge clk) disable iff (!rst_n)
    mq_push |-> (mq_count < bdm_pkg::MQ_CW'(bdm_pkg::MID_DEPTH)))
    else $error("work item pushed into a full work queue");

  // the credit check keeps the output queue from overflowing
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> !oq_full)
    else $error("result pushed into a full output queue");

  // a stalled input with room in the work queue always has the emitter pushing
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !mq_full) |=> $past(mq_push))
    else $error("input stalled while the emitter sat idle");

endmodule
